/* design/fgp_pkg.sv */
// Package for the fuzzy gain-scheduled PID controller.
// Holds widths, register indexes, controller command types and rule tables.
package fgp_pkg;

    localparam int DATA_W  = 16;
    localparam int LIM_W   = 15;
    localparam int STEP_W  = 48;
    localparam int CFG_W   = 48;
    localparam int IDX_W   = 3;
    localparam int RULE_LEVELS = 7;
    localparam int HALF_LEVELS = RULE_LEVELS / 2;
    localparam int LVL_W   = 3;
    localparam int GAIN_W  = 19;
    localparam int PROD_W  = 35;
    localparam int SUM_W   = 37;
    localparam int NUM_W   = 52;
    localparam int DEN_W   = 24;
    localparam int QUO_W   = NUM_W;
    localparam int DIV_CYC = NUM_W;

    localparam logic [IDX_W-1:0] REG_U_MAX  = 3'd0;
    localparam logic [IDX_W-1:0] REG_E_MAX  = 3'd1;
    localparam logic [IDX_W-1:0] REG_EC_MAX = 3'd2;
    localparam logic [IDX_W-1:0] REG_ES_MAX = 3'd3;
    localparam logic [IDX_W-1:0] REG_KP     = 3'd4;
    localparam logic [IDX_W-1:0] REG_KI     = 3'd5;
    localparam logic [IDX_W-1:0] REG_KD     = 3'd6;
    localparam logic [IDX_W-1:0] REG_STEP   = 3'd7;

    typedef struct packed {
        logic load;
        logic prime;
        logic quant;
        logic gains;
        logic mul_p;
        logic mul_i;
        logic mul_d;
        logic scale;
        logic div_start;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

    typedef logic signed [LVL_W-1:0] t_lvl;

    function automatic t_lvl rule_p(input logic [2:0] qe, input logic [2:0] qd);
        logic signed [2:0] t [0:48];
        t = '{3,3,2,2,1,0,0,  3,3,2,1,1,0,-1,  2,2,2,1,0,-1,-1,
              2,2,1,0,-1,-2,-2,  1,1,0,-1,-1,-2,-2,  1,0,-1,-2,-2,-2,-3,
              0,0,-2,-2,-2,-3,-3};
        return t[6'(qe) * 6'd7 + 6'(qd)];
    endfunction

    function automatic t_lvl rule_i(input logic [2:0] qe, input logic [2:0] qd);
        logic signed [2:0] t [0:48];
        t = '{-3,-3,-3,-3,-2,0,0,  -3,-3,-3,-3,-2,0,0,  -2,-2,-2,-2,0,1,1,
              -2,-2,-1,0,1,2,2,  -1,-1,0,2,2,2,2,  0,0,1,1,2,3,3,
              0,0,1,2,2,3,3};
        return t[6'(qe) * 6'd7 + 6'(qd)];
    endfunction

    function automatic t_lvl rule_d(input logic [2:0] qe, input logic [2:0] qd);
        logic signed [2:0] t [0:48];
        t = '{1,-1,-3,-3,-3,-2,1,  1,-1,-3,-2,-2,-1,0,  0,-1,-2,-2,-1,-1,0,
              0,-1,-1,-1,-1,-1,0,  0,0,0,0,0,0,0,  3,-1,1,1,1,1,3,
              3,2,2,2,1,1,3};
        return t[6'(qe) * 6'd7 + 6'(qd)];
    endfunction

endpackage

/* design/fgp_if.sv */
// Valid/ready channel interfaces for the controller.
// Depends on fgp_pkg for widths.
interface fgp_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [fgp_pkg::DATA_W-1:0]      error_sample;
    modport source (output valid, output error_sample, input ready);
    modport sink (input valid, input error_sample, output ready);
endinterface

interface fgp_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [fgp_pkg::DATA_W-1:0]      drive;
    logic                                   drive_saturated;
    modport source (output valid, output drive, output drive_saturated, input ready);
    modport sink (input valid, input drive, input drive_saturated, output ready);
endinterface

interface fgp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fgp_pkg::IDX_W-1:0]         index;
    logic [fgp_pkg::CFG_W-1:0]         data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* design/fgp_ctrl.sv */
// Controller state machine for the PID controller.
// Depends on fgp_pkg for command and status types.
module fgp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_first,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  fgp_pkg::t_stat     i_stat,
    output fgp_pkg::t_cmd      o_cmd
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_QUANT = 10'b0000000010,
        S_GAINS = 10'b0000000100,
        S_MULP  = 10'b0000001000,
        S_MULI  = 10'b0000010000,
        S_MULD  = 10'b0000100000,
        S_SCALE = 10'b0001000000,
        S_DIV   = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load  = 1'b1;
                    o_cmd.prime = i_first;
                    n_state = i_first ? S_OUT : S_QUANT;
                end
            end
            S_QUANT: begin
                o_cmd.quant = 1'b1;
                n_state = S_GAINS;
            end
            S_GAINS: begin
                o_cmd.gains = 1'b1;
                n_state = S_MULP;
            end
            S_MULP: begin
                o_cmd.mul_p = 1'b1;
                n_state = S_MULI;
            end
            S_MULI: begin
                o_cmd.mul_i = 1'b1;
                n_state = S_MULD;
            end
            S_MULD: begin
                o_cmd.mul_d = 1'b1;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

/* design/fgp_dp.sv */
// Datapath of the PID controller: state, quantizer, gains, products, divider.
// Depends on fgp_pkg for widths, rule tables and command types.
module fgp_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fgp_pkg::t_cmd                       i_cmd,
    output fgp_pkg::t_stat                      o_stat,
    input  logic signed [fgp_pkg::DATA_W-1:0]   i_sample,
    input  logic [fgp_pkg::LIM_W-1:0]           i_u_max,
    input  logic [fgp_pkg::LIM_W-1:0]           i_e_max,
    input  logic [fgp_pkg::LIM_W-1:0]           i_ec_max,
    input  logic [fgp_pkg::LIM_W-1:0]           i_es_max,
    input  logic signed [fgp_pkg::DATA_W-1:0]   i_kp_base,
    input  logic signed [fgp_pkg::DATA_W-1:0]   i_ki_base,
    input  logic signed [fgp_pkg::DATA_W-1:0]   i_kd_base,
    input  logic [fgp_pkg::STEP_W-1:0]          i_step,
    output logic                                o_first,
    output logic signed [fgp_pkg::DATA_W-1:0]   o_drive,
    output logic                                o_sat
);
    localparam int DW = fgp_pkg::DATA_W;
    localparam int NW = fgp_pkg::NUM_W;
    localparam int LIM_W_L = fgp_pkg::LIM_W;

    logic signed [DW-1:0] r_prev, r_sum, r_err;
    logic signed [DW:0]   r_de;
    logic                 r_first;
    logic [2:0]           r_qe, r_qd;
    logic signed [fgp_pkg::GAIN_W-1:0] r_kp, r_ki, r_kd;
    logic signed [fgp_pkg::SUM_W-1:0]  r_acc;
    logic [NW-1:0]        r_rem, r_quo, r_mag;
    logic                 r_neg;
    logic [6:0]           r_cnt;
    logic [fgp_pkg::DEN_W-1:0] r_den;
    logic signed [DW-1:0] r_drive;
    logic                 r_sat;

    logic [LIM_W_L-1:0]   em, ecm;
    logic signed [DW+1:0] sum_raw, sum_cl;
    logic signed [DW:0]   de_raw, de_cl, err_cl;
    logic [2:0]           qe_n, qd_n;
    logic signed [fgp_pkg::PROD_W-1:0] prod;
    logic signed [DW+1:0] mul_a;
    logic signed [fgp_pkg::GAIN_W-1:0] mul_b;
    logic signed [NW:0]   num;
    logic [NW:0]          rem_sh;
    logic [NW:0]          den2;
    logic [NW-1:0]        q_r;

    assign em  = (i_e_max == '0) ? LIM_W_L'(1) : i_e_max;
    assign ecm = (i_ec_max == '0) ? LIM_W_L'(1) : i_ec_max;
    assign sum_raw = 18'(r_sum) + 18'(i_sample);
    assign de_raw  = 17'(i_sample) - 17'(r_prev);

    function automatic logic signed [17:0] clampv(input logic signed [17:0] x,
                                                  input logic [14:0] lim);
        logic signed [17:0] l;
        l = $signed({3'b000, lim});
        if (x > l) return l;
        if (x < -l) return -l;
        return x;
    endfunction

    // Level index = 3 +/- round(3*|x|/span) by the sign of x, half away from zero, magnitude saturated at 3.
    function automatic logic [2:0] quant(input logic signed [16:0] x,
                                         input logic [14:0] span);
        logic [16:0] mag;
        logic [19:0] t, s;
        logic [2:0]  q;
        mag = x[16] ? 17'(-x) : 17'(x);
        t = 20'(mag) * 20'd6;
        s = {5'd0, span};
        q = 3'd0;
        if (t >= s) q = 3'd1;
        if (t >= 20'(s * 20'd3)) q = 3'd2;
        if (t >= 20'(s * 20'd5)) q = 3'd3;
        return x[16] ? 3'(3 - q) : 3'(3 + q);
    endfunction

    assign sum_cl = clampv(sum_raw, i_es_max);
    assign err_cl = 17'(clampv(18'(i_sample), em));
    assign de_cl  = 17'(clampv(18'(de_raw), ecm));

    assign qe_n = quant(r_err, em);
    assign qd_n = quant(r_de, ecm);

    always_comb begin
        mul_a = 18'(r_err);
        mul_b = r_kp;
        if (i_cmd.mul_i) begin
            mul_a = 18'(r_sum);
            mul_b = r_ki;
        end else if (i_cmd.mul_d) begin
            mul_a = 18'(r_de);
            mul_b = r_kd;
        end
    end
    assign prod = fgp_pkg::PROD_W'(mul_a) * fgp_pkg::PROD_W'(mul_b);
    assign num  = (NW+1)'(r_acc) * (NW+1)'($signed({1'b0, i_u_max}));
    assign den2 = (NW+1)'({r_den, 1'b0});
    assign rem_sh = {r_rem, r_mag[NW-1]};
    assign q_r = r_quo;

    assign o_stat.div_done = (r_cnt == 7'd1);
    assign o_first = r_first;
    assign o_drive = r_drive;
    assign o_sat   = r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_sum   <= '0;
            r_first <= 1'b1;
            r_cnt   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_prev <= i_sample;
                if (i_cmd.prime) begin
                    r_first <= 1'b0;
                    r_sum   <= '0;
                end else begin
                    r_sum  <= DW'(sum_cl);
                end
            end
            if (i_cmd.div_start) begin
                r_cnt <= 7'(fgp_pkg::DIV_CYC);
            end else if (i_cmd.div_step && r_cnt != '0) begin
                r_cnt <= r_cnt - 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_err  <= DW'(err_cl);
            r_de   <= de_cl;
            r_drive <= '0;
            r_sat   <= 1'b0;
        end
        if (i_cmd.quant) begin
            r_qe <= qe_n;
            r_qd <= qd_n;
        end
        if (i_cmd.gains) begin
            r_kp <= 19'(i_kp_base)
                    + 19'(fgp_pkg::rule_p(r_qe, r_qd)) * 19'($signed(i_step[15:0]));
            r_ki <= 19'(i_ki_base)
                    + 19'(fgp_pkg::rule_i(r_qe, r_qd)) * 19'($signed(i_step[31:16]));
            r_kd <= 19'(i_kd_base)
                    + 19'(fgp_pkg::rule_d(r_qe, r_qd)) * 19'($signed(i_step[47:32]));
            r_acc <= '0;
        end
        if (i_cmd.mul_p || i_cmd.mul_i) begin
            r_acc <= r_acc + fgp_pkg::SUM_W'(prod);
        end
        if (i_cmd.mul_d) begin
            r_acc <= r_acc - fgp_pkg::SUM_W'(prod);
        end
        if (i_cmd.scale) begin
            // Round half away: quotient of (2|num| + den) by 2*den, den = 256*e_max.
            r_neg <= num[NW];
            r_mag <= NW'((num[NW] ? -num : num) * 2 + (NW+1)'({em, 8'd0}));
            r_den <= {1'b0, em, 8'd0};
            r_rem <= '0;
            r_quo <= '0;
        end
        if (i_cmd.div_step && r_cnt != '0) begin
            if (rem_sh >= den2) begin
                r_rem <= NW'(rem_sh - den2);
                r_quo <= {r_quo[NW-2:0], 1'b1};
            end else begin
                r_rem <= NW'(rem_sh);
                r_quo <= {r_quo[NW-2:0], 1'b0};
            end
            r_mag <= {r_mag[NW-2:0], 1'b0};
        end
        if (i_cmd.finish) begin
            if (q_r > NW'(i_u_max)) begin
                r_sat   <= 1'b1;
                r_drive <= r_neg ? -DW'(i_u_max) : DW'(i_u_max);
            end else begin
                r_sat   <= 1'b0;
                r_drive <= r_neg ? -DW'(q_r) : DW'(q_r);
            end
        end
    end
endmodule

/* design/fuzzy_gain_scheduled_pid.sv */
// Top level of the fuzzy gain-scheduled PID controller: config registers,
// controller and datapath. Depends on fgp_pkg, fgp_if, fgp_ctrl and fgp_dp.
//
//   channel   dir  payload
//   in        in   error_sample
//   out       out  drive, drive_saturated
//   cfg       in   index, data
//
// A priming sample goes straight to the output; every other sample runs
// the 52-step restoring divider. Sample n+1 is accepted only after
// the result of sample n has been transferred. Reset is synchronous and
// needs no clearing pass. Configuration writes are always taken.
module fuzzy_gain_scheduled_pid (
    input  logic     i_clk,
    input  logic     i_rst_n,
    fgp_in_if.sink   in_ch,
    fgp_out_if.source out_ch,
    fgp_cfg_if.sink  cfg_ch
);
    logic [fgp_pkg::LIM_W-1:0]         r_u_max, r_e_max, r_ec_max, r_es_max;
    logic signed [fgp_pkg::DATA_W-1:0] r_kp, r_ki, r_kd;
    logic [fgp_pkg::STEP_W-1:0]        r_step;
    fgp_pkg::t_cmd  cmd;
    fgp_pkg::t_stat stat;
    logic           first;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_max <= 15'd256;
            r_e_max <= 15'd256;
            r_ec_max <= 15'd256;
            r_es_max <= 15'd256;
            r_kp <= '0;
            r_ki <= '0;
            r_kd <= '0;
            r_step <= '0;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.index)
                fgp_pkg::REG_U_MAX:  r_u_max  <= cfg_ch.data[14:0];
                fgp_pkg::REG_E_MAX:  r_e_max  <= cfg_ch.data[14:0];
                fgp_pkg::REG_EC_MAX: r_ec_max <= cfg_ch.data[14:0];
                fgp_pkg::REG_ES_MAX: r_es_max <= cfg_ch.data[14:0];
                fgp_pkg::REG_KP:     r_kp     <= cfg_ch.data[15:0];
                fgp_pkg::REG_KI:     r_ki     <= cfg_ch.data[15:0];
                fgp_pkg::REG_KD:     r_kd     <= cfg_ch.data[15:0];
                fgp_pkg::REG_STEP:   r_step   <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    fgp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .i_first     (first),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fgp_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_sample  (in_ch.error_sample),
        .i_u_max   (r_u_max),
        .i_e_max   (r_e_max),
        .i_ec_max  (r_ec_max),
        .i_es_max  (r_es_max),
        .i_kp_base (r_kp),
        .i_ki_base (r_ki),
        .i_kd_base (r_kd),
        .i_step    (r_step),
        .o_first   (first),
        .o_drive   (out_ch.drive),
        .o_sat     (out_ch.drive_saturated)
    );
endmodule
